### hdl/cldf_pkg.sv
`default_nettype none
package cldf_pkg;

	localparam int TABLE_LEN       = 7;
	localparam int NUM_SOURCES_DEF = 7;

	localparam int REG_IDX_W  = 2;
	localparam int REG_DATA_W = 16;

	localparam logic [REG_IDX_W-1:0] REG_PANEL_DISTANCE   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RANDOMS_MODE     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_FINE_TIME_WINDOW = 2'd2;

	localparam logic [15:0] FINE_WINDOW_RST = 16'd40;

	// event fields
	typedef struct packed {
		logic signed [15:0] fine_time_diff;
		logic [11:0]        energy_one;
		logic [11:0]        energy_two;
		logic [6:0]         crystal_one;
		logic [6:0]         crystal_two;
		logic               apd_one;
		logic               apd_two;
		logic [3:0]         module_one;
		logic [3:0]         module_two;
		logic [2:0]         fin_one;
		logic [2:0]         fin_two;
		logic [17:0]        stage_position;
	} evt_t;

	// result fields
	typedef struct packed {
		logic               accepted;
		logic signed [19:0] end_one_x;
		logic signed [19:0] end_one_y;
		logic signed [19:0] end_one_z;
		logic signed [19:0] end_two_x;
		logic signed [19:0] end_two_y;
		logic signed [19:0] end_two_z;
		logic [19:0]        closest_sq;
		logic [2:0]         source_index;
	} res_t;

	// point source positions, Q8 mm
	function automatic logic signed [15:0] src_x(input logic [2:0] i);
		logic signed [15:0] v;
		unique case (i)
			3'd0: v = -16'sd14239;
			3'd1: v = -16'sd9119;
			3'd2: v = -16'sd4019;
			3'd3: v = 16'sd1096;
			3'd4: v = 16'sd6203;
			3'd5: v = 16'sd11290;
			3'd6: v = 16'sd16484;
			default: v = 16'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [15:0] src_y(input logic [2:0] i);
		logic signed [15:0] v;
		unique case (i)
			3'd0: v = 16'sd852;
			3'd1: v = 16'sd852;
			3'd2: v = 16'sd906;
			3'd3: v = 16'sd960;
			3'd4: v = 16'sd1014;
			3'd5: v = 16'sd1068;
			3'd6: v = 16'sd1121;
			default: v = 16'sd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### hdl/cldf_if.sv
`default_nettype none
interface cldf_evt_if;
	logic            valid;
	logic            ready;
	cldf_pkg::evt_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface cldf_res_if;
	logic            valid;
	logic            ready;
	cldf_pkg::res_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/coincidence_lor_dca_filter_top.sv
`default_nettype none
// channel   dir   payload
// evt       in    cldf_pkg::evt_t, one coincidence event per beat
// res       out   cldf_pkg::res_t, one result per event, same order
// wr_*      in    register write: wr_en, reg_index, wr_data
//
// One event per cycle unless res.ready stalls the pipeline: 8 geometry/product stages, then
// a 20-stage restoring divider, one quotient bit per stage.
// arst_n clears the valid bits and loads register reset values.
// The whole pipeline holds while a result waits on res.ready.
module coincidence_lor_dca_filter_top #(
	parameter int NUM_SOURCES = cldf_pkg::NUM_SOURCES_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	cldf_evt_if.sink                             evt,
	cldf_res_if.source                           res,
	input  wire                                  wr_en,
	input  wire [cldf_pkg::REG_IDX_W-1:0]        reg_index,
	input  wire [cldf_pkg::REG_DATA_W-1:0]       wr_data
);

	localparam int DIV_N = 20;
	localparam logic [29:0] RECIP_1250 = 30'd879609302; // floor(2^40 / 1250)

	typedef struct packed {
		logic              ok;
		logic              dz;
		logic [2:0]        idx;
		logic [5:0][19:0]  ep;
	} meta_t;

	// ---------------- registers ----------------
	logic [9:0]  panel_distance_q;
	logic        randoms_mode_q;
	logic [15:0] fine_time_window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_distance_q   <= '0;
			randoms_mode_q     <= 1'b0;
			fine_time_window_q <= cldf_pkg::FINE_WINDOW_RST;
		end else if (wr_en) begin
			unique case (reg_index)
				cldf_pkg::REG_PANEL_DISTANCE:   panel_distance_q   <= wr_data[9:0];
				cldf_pkg::REG_RANDOMS_MODE:     randoms_mode_q     <= wr_data[0];
				cldf_pkg::REG_FINE_TIME_WINDOW: fine_time_window_q <= wr_data;
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic div_vld_s [0:DIV_N];

	assign en        = !div_vld_s[DIV_N] || res.ready;
	assign evt.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= evt.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// ---------------- stage 1: qualify, endpoint numerators ----------------
	cldf_pkg::evt_t     e;
	logic [16:0]        dt_mag;
	logic [3:0]         idx_c;
	logic               ok_c;
	logic signed [31:0] m1, m2, k1, k2, r1, r2, f1, f2, a1, a2, yh;
	logic signed [31:0] v [0:5];
	logic [28:0]        x_c [0:5];

	assign e = evt.data;

	always_comb begin
		dt_mag = e.fine_time_diff[15] ? 17'(-(17'(e.fine_time_diff)))
		                              : 17'(e.fine_time_diff);
		idx_c = '0;
		for (int k = 1; k <= 12; k++) begin
			idx_c = idx_c + 4'(e.stage_position >= 18'(15000 + 20000 * k));
		end
		ok_c = (randoms_mode_q || (dt_mag < 17'(fine_time_window_q)))
		    && e.energy_one > 12'd400 && e.energy_one < 12'd700
		    && e.energy_two > 12'd400 && e.energy_two < 12'd700
		    && e.crystal_one < 7'd64 && e.crystal_two < 7'd64
		    && e.stage_position >= 18'd15000
		    && idx_c < 4'(NUM_SOURCES) && idx_c < 4'(cldf_pkg::TABLE_LEN);

		m1 = 32'($signed({1'b0, e.module_one}));
		m2 = 32'($signed({1'b0, e.module_two}));
		k1 = 32'($signed({1'b0, e.crystal_one[5:3]}));
		k2 = 32'($signed({1'b0, e.crystal_two[5:3]}));
		r1 = 32'($signed({1'b0, e.crystal_one[2:0]}));
		r2 = 32'($signed({1'b0, e.crystal_two[2:0]}));
		f1 = 32'($signed({1'b0, e.fin_one}));
		f2 = 32'($signed({1'b0, e.fin_two}));
		a1 = 32'($signed({1'b0, e.apd_one}));
		a2 = 32'($signed({1'b0, e.apd_two}));
		yh = 32'($signed({1'b0, panel_distance_q})) * 32'sd10000 + 32'sd30200;

		// 1/20000 mm units
		v[0] = 32'sd32870 + (m1 - 32'sd8) * 32'sd205740 + k1 * 32'sd20000;
		v[1] = yh + a1 * 32'sd202692 + (32'sd7 - r1) * 32'sd20000 + 32'sd10000;
		v[2] = -32'sd14351 + (32'sd4 - f1) * 32'sd28702;
		v[3] = 32'sd32870 + (32'sd7 - m2) * 32'sd205740 + (32'sd7 - k2) * 32'sd20000;
		v[4] = -(yh + a2 * 32'sd202692 + (32'sd7 - r2) * 32'sd20000 + 32'sd10000);
		v[5] = -32'sd14351 + (32'sd4 - f2) * 32'sd28702;
		// round half up to Q8: floor((16v + 625) / 1250), biased positive by 1250 * 2^18
		for (int j = 0; j < 6; j++) begin
			x_c[j] = 29'(v[j] * 32'sd16 + 32'sd625 + 32'sd327680000);
		end
	end

	logic        ok_s1, ok_s2;
	logic [2:0]  idx_s1, idx_s2;
	logic [28:0] x_s1 [0:5];
	logic [28:0] x_s2 [0:5];
	logic [18:0] q0_s2 [0:5];
	logic [58:0] prod_c [0:5];

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1  <= ok_c;
			idx_s1 <= idx_c[2:0];
			x_s1   <= x_c;
		end
	end

	// ---------------- stage 2: reciprocal multiply ----------------
	always_comb begin
		for (int j = 0; j < 6; j++) begin
			prod_c[j] = 59'(x_s1[j]) * 59'(RECIP_1250);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s2  <= ok_s1;
			idx_s2 <= idx_s1;
			x_s2   <= x_s1;
			for (int j = 0; j < 6; j++) begin
				q0_s2[j] <= prod_c[j][58:40];
			end
		end
	end

	// ---------------- stage 3: quotient correction, unbias ----------------
	meta_t       meta_c3;
	logic [29:0] rem_c3;
	logic [19:0] q_c3;

	always_comb begin
		meta_c3     = '0;
		meta_c3.ok  = ok_s2;
		meta_c3.idx = idx_s2;
		rem_c3      = '0;
		q_c3        = '0;
		for (int j = 0; j < 6; j++) begin
			rem_c3 = 30'(x_s2[j]) - 30'(q0_s2[j]) * 30'd1250;
			q_c3   = 20'(q0_s2[j]) + 20'(rem_c3 >= 30'd1250);
			meta_c3.ep[j] = q_c3 - 20'd262144;
		end
	end

	meta_t meta_s3, meta_s4, meta_s5, meta_s6, meta_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s3 <= meta_c3;
		end
	end

	// ---------------- stage 4: difference vectors ----------------
	logic signed [20:0] a_s4 [0:2];
	logic signed [20:0] b_s4 [0:2];

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s4 <= meta_s3;
			a_s4[0] <= 21'($signed(meta_s3.ep[0])) - 21'(cldf_pkg::src_x(meta_s3.idx));
			a_s4[1] <= 21'($signed(meta_s3.ep[1])) - 21'(cldf_pkg::src_y(meta_s3.idx));
			a_s4[2] <= 21'($signed(meta_s3.ep[2]));
			for (int j = 0; j < 3; j++) begin
				b_s4[j] <= 21'($signed(meta_s3.ep[3+j])) - 21'($signed(meta_s3.ep[j]));
			end
		end
	end

	// ---------------- stage 5: cross and square products ----------------
	logic signed [41:0] t_s5 [0:5];
	logic signed [41:0] bb_s5 [0:2];

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s5  <= meta_s4;
			t_s5[0]  <= 42'(a_s4[1]) * 42'(b_s4[2]);
			t_s5[1]  <= 42'(a_s4[2]) * 42'(b_s4[1]);
			t_s5[2]  <= 42'(a_s4[2]) * 42'(b_s4[0]);
			t_s5[3]  <= 42'(a_s4[0]) * 42'(b_s4[2]);
			t_s5[4]  <= 42'(a_s4[0]) * 42'(b_s4[1]);
			t_s5[5]  <= 42'(a_s4[1]) * 42'(b_s4[0]);
			for (int j = 0; j < 3; j++) begin
				bb_s5[j] <= 42'(b_s4[j]) * 42'(b_s4[j]);
			end
		end
	end

	// ---------------- stage 6: cross product, |b|^2 ----------------
	logic signed [42:0] cr_s6 [0:2];
	logic [39:0]        bsq_s6, bsq_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s6  <= meta_s5;
			cr_s6[0] <= 43'(t_s5[0]) - 43'(t_s5[1]);
			cr_s6[1] <= 43'(t_s5[2]) - 43'(t_s5[3]);
			cr_s6[2] <= 43'(t_s5[4]) - 43'(t_s5[5]);
			bsq_s6   <= 40'(bb_s5[0]) + 40'(bb_s5[1]) + 40'(bb_s5[2]);
		end
	end

	// ---------------- stage 7: squares of the cross product ----------------
	logic [42:0] crm_c [0:2];
	logic [71:0] sq_s7 [0:2];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			crm_c[j] = cr_s6[j] < 0 ? 43'(-cr_s6[j]) : 43'(cr_s6[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s7 <= meta_s6;
			bsq_s7  <= bsq_s6;
			for (int j = 0; j < 3; j++) begin
				// magnitude stays below 2^35 for every reachable geometry
				sq_s7[j] <= 72'(crm_c[j][35:0]) * 72'(crm_c[j][35:0]);
			end
		end
	end

	// ---------------- stage 8 and divider ----------------
	logic [71:0] div_rem_s [0:DIV_N];
	logic [39:0] div_den_s [0:DIV_N];
	logic [19:0] div_quo_s [0:DIV_N];
	meta_t       div_meta_s [0:DIV_N];
	meta_t       meta_c8;

	always_comb begin
		meta_c8    = meta_s7;
		meta_c8.dz = (bsq_s7 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s[0] <= 1'b0;
		end else if (en) begin
			div_vld_s[0] <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_rem_s[0]  <= sq_s7[0] + sq_s7[1] + sq_s7[2];
			div_den_s[0]  <= bsq_s7;
			div_quo_s[0]  <= '0;
			div_meta_s[0] <= meta_c8;
		end
	end

	for (genvar g = 1; g <= DIV_N; g++) begin : g_div
		localparam int SH = DIV_N - g + 8;
		logic [71:0] dk;
		logic        ge;

		assign dk = 72'(div_den_s[g-1]) << SH;
		assign ge = div_rem_s[g-1] >= dk;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[g] <= 1'b0;
			end else if (en) begin
				div_vld_s[g] <= div_vld_s[g-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_rem_s[g]  <= ge ? div_rem_s[g-1] - dk : div_rem_s[g-1];
				div_quo_s[g]  <= div_quo_s[g-1] | (ge ? 20'(1) << (DIV_N - g) : 20'd0);
				div_den_s[g]  <= div_den_s[g-1];
				div_meta_s[g] <= div_meta_s[g-1];
			end
		end
	end

	// ---------------- output ----------------
	meta_t mo;
	assign mo        = div_meta_s[DIV_N];
	assign res.valid = div_vld_s[DIV_N];

	always_comb begin
		res.data = '0;
		if (mo.ok) begin
			res.data.accepted     = 1'b1;
			res.data.end_one_x    = $signed(mo.ep[0]);
			res.data.end_one_y    = $signed(mo.ep[1]);
			res.data.end_one_z    = $signed(mo.ep[2]);
			res.data.end_two_x    = $signed(mo.ep[3]);
			res.data.end_two_y    = $signed(mo.ep[4]);
			res.data.end_two_z    = $signed(mo.ep[5]);
			res.data.closest_sq   = mo.dz ? 20'd0 : div_quo_s[DIV_N];
			res.data.source_index = mo.idx;
		end
	end

endmodule
`default_nettype wire

### hdl/cldf_checker.sv
`default_nettype none
module cldf_checker (
	input wire             clk,
	input wire             arst_n,
	input wire             res_valid,
	input wire             res_ready,
	input cldf_pkg::res_t  res_data
);

	// a waiting result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// rejected events carry all-zero fields
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.accepted |->
			res_data.end_one_x == 0 && res_data.end_one_y == 0 &&
			res_data.end_one_z == 0 && res_data.end_two_x == 0 &&
			res_data.end_two_y == 0 && res_data.end_two_z == 0 &&
			res_data.closest_sq == 0 && res_data.source_index == 0)
		else $error("rejected result not zero");

	a_src_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.accepted |->
			res_data.source_index < 3'(cldf_pkg::TABLE_LEN))
		else $error("source index out of table");

	// first endpoint sits on the upper panel, second on the lower
	a_panel_side: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.accepted |->
			res_data.end_one_y > 0 && res_data.end_two_y < 0)
		else $error("endpoint on wrong panel");

endmodule

bind coincidence_lor_dca_filter_top cldf_checker u_cldf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
`default_nettype wire
